### src/lba_pkg.sv
// lba_pkg: shared types and constants for the link bandwidth admission block.
// No dependencies.
package lba_pkg;

	localparam int COST_W   = 16;  // cost field width
	localparam int BW_W     = 40;  // clamped request bandwidth width
	localparam int LBW_W    = 42;  // stored limit / used bandwidth width
	localparam int LIDX_W   = 4;   // link index field width
	localparam int TIDX_W   = 8;   // ticket index field width
	localparam int KBPS_W   = 31;
	localparam int PROD_W   = LBW_W + COST_W;  // used * MAX_COST
	localparam int DCNT_W   = $clog2(COST_W);

	localparam int LINKS_DEF    = 16;
	localparam int TICKETS_DEF  = 256;
	localparam int MAX_COST_DEF = 10000;
	localparam int OOS_COST_DEF = 10001;

	localparam logic [9:0] KBPS_SCALE = 10'd1000;
	localparam logic [1:0] TYPE_UNSUPPORTED = 2'd3;

	typedef enum logic [1:0] {
		CMD_EVAL   = 2'd0,
		CMD_NARROW = 2'd1,
		CMD_FREE   = 2'd2,
		CMD_CONFIG = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_NO_BW   = 2'd2,
		ST_BAD_TYPE = 2'd3
	} status_t;

	typedef struct packed {
		logic [LBW_W-1:0] limit;
		logic [LBW_W-1:0] used;
	} link_entry_t;

	typedef struct packed {
		logic [BW_W-1:0]   bw;
		logic [LIDX_W-1:0] link;
	} ticket_entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### src/link_bandwidth_admission.sv
// link_bandwidth_admission: per-link bandwidth admission table.
// Configure, narrow and most evaluates decide on the link table read; a free of a
// recorded ticket adds a second link read; an evaluate that divides waits on the divider.
// One word at a time: busy is high from acceptance until the done strobe, and
// the next word is taken in the strobe cycle. The divider sets the worst case.
// Reset (arst_n low) clears all link and ticket valid bits; table data is not cleared.
module link_bandwidth_admission import lba_pkg::*; #(
	parameter int LINKS               = LINKS_DEF,
	parameter int TICKETS             = TICKETS_DEF,
	parameter int MAX_COST            = MAX_COST_DEF,
	parameter int OUT_OF_SERVICE_COST = OOS_COST_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [LIDX_W-1:0] link_index,
	input  logic [1:0]        link_type,
	input  logic [TIDX_W-1:0] ticket_index,
	input  logic [40:0]       request_bw,
	input  logic [40:0]       hint_bw,
	input  logic [COST_W-1:0] old_cost,
	input  logic [KBPS_W-1:0] total_bw_kbps,
	input  logic              in_service,
	output logic              done,
	output logic [COST_W-1:0] cost,
	output logic [1:0]        status,
	output logic [BW_W-1:0]   granted_bw
);

	localparam int LW = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int TW = (TICKETS > 1) ? $clog2(TICKETS) : 1;
	localparam logic [COST_W-1:0] MAXC = COST_W'(MAX_COST);
	localparam logic [COST_W-1:0] OOSC = COST_W'(OUT_OF_SERVICE_COST);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,   // table read data valid, decide
		S_FREE,   // second link read for a released ticket
		S_DIV     // waiting on the cost divider
	} state_t;

	state_t state_q;

	// output word registers
	logic              done_q;
	logic [COST_W-1:0] cost_q;
	status_t           status_q;
	logic [BW_W-1:0]   grant_q;

	// accepted command word
	cmd_t              cmd_q;
	logic [LIDX_W-1:0] li_q;
	logic              li_ok_q;
	logic              bad_type_q;
	logic [TIDX_W-1:0] ti_q;
	logic              ti_ok_q;
	logic [BW_W-1:0]   req_q;     // request, negatives clamped to zero
	logic [BW_W-1:0]   evreq_q;   // max(request, hint) for evaluate
	logic [COST_W-1:0] old_cost_q;
	logic [KBPS_W-1:0] kbps_q;
	logic              insvc_q;

	logic accept;
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// clamp and hint merge at the input
	logic [BW_W-1:0] req_c;
	logic [BW_W-1:0] hint_c;
	logic            hint_ok;
	assign req_c   = request_bw[40] ? '0 : request_bw[BW_W-1:0];
	assign hint_c  = hint_bw[BW_W-1:0];
	assign hint_ok = !hint_bw[40];

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(command);
			li_q       <= link_index;
			li_ok_q    <= (32'(link_index) < LINKS);
			bad_type_q <= (link_type == TYPE_UNSUPPORTED);
			ti_q       <= ticket_index;
			ti_ok_q    <= (32'(ticket_index) < TICKETS);
			req_q      <= req_c;
			evreq_q    <= (hint_ok && hint_c > req_c) ? hint_c : req_c;
			old_cost_q <= old_cost;
			kbps_q     <= total_bw_kbps;
			insvc_q    <= in_service;
		end
	end

	// ---------------------------------------------------------------
	// tables
	// ---------------------------------------------------------------
	link_entry_t   lrd;
	logic          lrd_vld;
	logic          lrd_en;
	logic [LW-1:0] lrd_addr;
	logic          lwr_en;
	logic [LW-1:0] lwr_addr;
	link_entry_t   lwr;

	ticket_entry_t trd;
	logic          trd_vld;
	logic          twr_en;
	logic          tclr_en;
	ticket_entry_t twr;

	lba_link_tbl #(
		.LINKS (LINKS),
		.LW    (LW)
	) u_link_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (lrd_en),
		.rd_addr  (lrd_addr),
		.rd_entry (lrd),
		.rd_vld   (lrd_vld),
		.wr_en    (lwr_en),
		.wr_addr  (lwr_addr),
		.wr_entry (lwr)
	);

	lba_ticket_tbl #(
		.TICKETS (TICKETS),
		.TW      (TW)
	) u_ticket_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (TW'(ticket_index)),
		.rd_entry (trd),
		.rd_vld   (trd_vld),
		.wr_en    (twr_en),
		.clr_en   (tclr_en),
		.wr_addr  (TW'(ti_q)),
		.wr_entry (twr)
	);

	// ---------------------------------------------------------------
	// cost divider: used * MAX_COST / limit
	// ---------------------------------------------------------------
	logic              go_div;
	logic [PROD_W-1:0] product;
	logic [COST_W-1:0] quot;
	div_stat_t         div_stat;

	assign product = PROD_W'(lrd.used) * PROD_W'(MAXC);

	lba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_div),
		.dividend (product),
		.divisor  (lrd.limit),
		.quot     (quot),
		.stat     (div_stat)
	);

	// ---------------------------------------------------------------
	// decision logic
	// ---------------------------------------------------------------
	logic             link_ok;
	logic             lim_zero;
	logic [LBW_W:0]   sum_ev;
	logic [LBW_W:0]   sum_nr;
	logic             over_ev;
	logic             over_nr;
	logic [LBW_W-1:0] cfg_limit;
	logic             go_free;
	logic [COST_W-1:0] n_cost;
	status_t          n_status;
	logic [BW_W-1:0]  n_grant;

	assign link_ok   = li_ok_q && lrd_vld;
	assign lim_zero  = (lrd.limit == '0);
	assign sum_ev    = {1'b0, lrd.used} + (LBW_W+1)'(evreq_q);
	assign sum_nr    = {1'b0, lrd.used} + (LBW_W+1)'(req_q);
	assign over_ev   = sum_ev > {1'b0, lrd.limit};
	assign over_nr   = sum_nr > {1'b0, lrd.limit};
	assign cfg_limit = LBW_W'(kbps_q) * LBW_W'(KBPS_SCALE);

	// read address: command's link on accept, ticket's link during a free
	assign lrd_en   = accept || go_free;
	assign lrd_addr = accept ? LW'(link_index) : LW'(trd.link);
	assign lwr_addr = (state_q == S_FREE) ? LW'(trd.link) : LW'(li_q);

	assign twr.bw   = req_q;
	assign twr.link = li_q;

	always_comb begin
		n_cost   = '0;
		n_status = ST_OK;
		n_grant  = '0;
		go_div   = 1'b0;
		go_free  = 1'b0;
		lwr_en   = 1'b0;
		lwr      = lrd;
		twr_en   = 1'b0;
		tclr_en  = 1'b0;
		if (state_q == S_READ) begin
			case (cmd_q)
				CMD_EVAL: begin
					if (bad_type_q) begin
						n_cost   = OOSC;
						n_status = ST_BAD_TYPE;
					end else if (old_cost_q > MAXC) begin
						n_cost = old_cost_q;
					end else if (!link_ok) begin
						n_cost   = OOSC;
						n_status = ST_UNKNOWN;
					end else if (lim_zero) begin
						n_grant = evreq_q;
					end else if (over_ev) begin
						n_cost   = OOSC;
						n_status = ST_NO_BW;
						n_grant  = evreq_q;
					end else begin
						go_div = 1'b1;
					end
				end
				CMD_NARROW: begin
					if (!link_ok) begin
						n_cost   = OOSC;
						n_status = ST_UNKNOWN;
					end else if (lim_zero) begin
						n_grant = req_q;
					end else if (over_nr) begin
						n_cost   = OOSC;
						n_status = ST_NO_BW;
					end else if (!ti_ok_q) begin
						n_cost   = OOSC;
						n_status = ST_UNKNOWN;
					end else begin
						// an older record in the slot is overwritten, not released
						twr_en   = 1'b1;
						lwr_en   = 1'b1;
						lwr.used = sum_nr[LBW_W-1:0];
						n_grant  = req_q;
					end
				end
				CMD_FREE: begin
					if (ti_ok_q && trd_vld) begin
						tclr_en = 1'b1;
						go_free = 1'b1;
					end
				end
				CMD_CONFIG: begin
					if (bad_type_q) begin
						n_cost   = OOSC;
						n_status = ST_BAD_TYPE;
					end else if (!li_ok_q) begin
						n_cost   = OOSC;
						n_status = ST_UNKNOWN;
					end else begin
						lwr_en    = 1'b1;
						lwr.limit = cfg_limit;
						lwr.used  = (insvc_q && lrd_vld) ? lrd.used : '0;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_FREE) begin
			// release: subtract, saturating at zero
			n_grant = trd.bw;
			if (lrd_vld) begin
				lwr_en   = 1'b1;
				lwr.used = (lrd.used > LBW_W'(trd.bw)) ? lrd.used - LBW_W'(trd.bw) : '0;
			end
		end
	end

	// ---------------------------------------------------------------
	// sequencer and output word
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			cost_q   <= '0;
			status_q <= ST_OK;
			grant_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_READ;
				end
				S_READ: begin
					if (go_div) begin
						state_q <= S_DIV;
					end else if (go_free) begin
						state_q <= S_FREE;
					end else begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						cost_q   <= n_cost;
						status_q <= n_status;
						grant_q  <= n_grant;
					end
				end
				S_FREE: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					cost_q   <= n_cost;
					status_q <= n_status;
					grant_q  <= n_grant;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						cost_q   <= quot;
						status_q <= ST_OK;
						grant_q  <= evreq_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign cost       = cost_q;
	assign status     = status_q;
	assign granted_bw = grant_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_one_word_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not raise busy");

	a_reject_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_UNKNOWN || status == ST_NO_BW || status == ST_BAD_TYPE))
		|-> (cost == OOSC))
		else $error("rejected word without out-of-service cost");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> (state_q == S_DIV))
		else $error("divider active outside evaluate");

endmodule

### src/lba_div.sv
// lba_div: restoring divider, one quotient bit per cycle.
// Depends on lba_pkg. Quotient must fit in COST_W bits.
module lba_div import lba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [LBW_W-1:0]  divisor,
	output logic [COST_W-1:0] quot,
	output div_stat_t         stat
);

	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dvs_q;
	logic [COST_W-1:0] quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic              ge;

	assign ge = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_W'(COST_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: divisor starts aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= PROD_W'(divisor) << (COST_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge)
				rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[COST_W-2:0], ge};
		end
	end

	assign quot      = quo_q;
	assign stat.busy = run_q;
	assign stat.done = done_q;

endmodule

### src/lba_link_tbl.sv
// lba_link_tbl: link table memory (limit, used) with per-link valid bits.
// Depends on lba_pkg. One read, one write port; read data registered.
module lba_link_tbl import lba_pkg::*; #(
	parameter int LINKS = LINKS_DEF,
	parameter int LW    = (LINKS > 1) ? $clog2(LINKS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [LW-1:0] rd_addr,
	output link_entry_t   rd_entry,
	output logic          rd_vld,
	input  logic          wr_en,
	input  logic [LW-1:0] wr_addr,
	input  link_entry_t   wr_entry
);

	link_entry_t      mem_q [LINKS];
	logic [LINKS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_entry;
		if (rd_en)
			rd_entry <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rd_vld <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld <= (32'(rd_addr) < LINKS) ? vld_q[rd_addr] : 1'b0;
		end
	end

endmodule

### src/lba_ticket_tbl.sv
// lba_ticket_tbl: ticket memory (bandwidth, link) with per-slot valid bits.
// Depends on lba_pkg. Record sets a slot, release clears its valid bit.
module lba_ticket_tbl import lba_pkg::*; #(
	parameter int TICKETS = TICKETS_DEF,
	parameter int TW      = (TICKETS > 1) ? $clog2(TICKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [TW-1:0] rd_addr,
	output ticket_entry_t rd_entry,
	output logic          rd_vld,
	input  logic          wr_en,
	input  logic          clr_en,
	input  logic [TW-1:0] wr_addr,
	input  ticket_entry_t wr_entry
);

	ticket_entry_t      mem_q [TICKETS];
	logic [TICKETS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_entry;
		if (rd_en)
			rd_entry <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rd_vld <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			else if (clr_en)
				vld_q[wr_addr] <= 1'b0;
			if (rd_en)
				rd_vld <= (32'(rd_addr) < TICKETS) ? vld_q[rd_addr] : 1'b0;
		end
	end

endmodule
